// ===== hdl/b2d_pkg.sv =====
// Shared types and constants for the 128-bit binary to decimal digit converter.
// No dependencies; used by the controller, the datapath and the top level.
package b2d_pkg;

  localparam int BIN_W     = 128;
  localparam int HALF_W    = 64;
  localparam int DIGITS    = 39;
  localparam int BCD_W     = DIGITS * 4;
  localparam int BIT_CNT_W = $clog2(BIN_W);
  localparam int DIG_CNT_W = $clog2(DIGITS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new value and clear the BCD register
    logic conv;   // one double-dabble adjust-and-shift step
    logic skip;   // drop a leading zero digit
    logic emit;   // move the top digit into the output register
  } b2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_end;  // the step now running is the last conversion shift
    logic top_zero;  // the top BCD digit is zero
    logic dig_zero;  // the top BCD digit is the least significant one
    logic out_free;  // the output register can take a digit this cycle
  } b2d_status_t;

endpackage

// ===== hdl/b2d_ctrl.sv =====
// Controller state machine of the binary to decimal converter.
// Depends on b2d_pkg for the command and status structs.
module b2d_ctrl import b2d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  b2d_status_t status,
  output b2d_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_end) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // Leading zeros are shifted out, but the units digit always stays.
        if (status.top_zero && !status.dig_zero) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.dig_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/b2d_datapath.sv =====
// Datapath of the binary to decimal converter: binary and BCD shift registers,
// step counters and the output digit register. Depends on b2d_pkg.
module b2d_datapath import b2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  b2d_cmd_t           cmd,
  output b2d_status_t        status,
  input  logic [HALF_W-1:0]  value_high,
  input  logic [HALF_W-1:0]  value_low,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         digit,
  output logic               last_digit
);

  logic [BIN_W-1:0]     bin;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DIG_CNT_W-1:0] dig_cnt;
  logic [3:0]           top_digit;

  assign top_digit = bcd[BCD_W-1 -: 4];

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= {value_high, value_low};
      bcd     <= '0;
      bit_cnt <= BIT_CNT_W'(BIN_W - 1);
      dig_cnt <= DIG_CNT_W'(DIGITS - 1);
    end else if (cmd.conv) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
      bit_cnt    <= bit_cnt - 1'b1;
    end else if (cmd.skip || cmd.emit) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit      <= top_digit;
      last_digit <= (dig_cnt == '0);
    end
  end

  assign status.conv_end = (bit_cnt == '0);
  assign status.top_zero = (top_digit == 4'd0);
  assign status.dig_zero = (dig_cnt == '0);
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== hdl/binary128_to_decimal_digits.sv =====
// Top level of the 128-bit binary to decimal digit converter.
// Depends on b2d_pkg, b2d_ctrl and b2d_datapath.
//
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-----------------------------------
// in      | input     | in_valid/in_stall  | value_high[63:0], value_low[63:0]
// out     | output    | out_valid/out_stall| digit[3:0], last_digit
//
// Each item is accepted, then passes one double-dabble shift per input bit, and
// then the digit phase: a step per dropped leading zero, a step to move from
// dropping zeros to emitting, and a step per digit handed to the output register.
// The output register takes one digit per cycle while out_stall is low, and
// output stalls lengthen the digit phase.
// Reset is synchronous and active high; it clears the controller state and
// the output valid flag. A new item is taken while the last digit still waits.
module binary128_to_decimal_digits import b2d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HALF_W-1:0] value_high,
  input  logic [HALF_W-1:0] value_low,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        digit,
  output logic              last_digit
);

  b2d_cmd_t    cmd;
  b2d_status_t status;

  // The controller sequences load, conversion, leading-zero skip and emit.
  b2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the value, the BCD digits and the output register.
  b2d_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .value_high (value_high),
    .value_low  (value_low),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit      (digit),
    .last_digit (last_digit)
  );

`ifndef NO_ASSERTIONS
  // A shown digit is always a valid decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit <= 4'd9))
    else $error("digit out of decimal range");

  // Once an item is taken, the input side stalls while it converts.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted during conversion");

  // After the last digit is taken, no further digit follows at once.
  a_no_digit_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_digit) |=> !out_valid)
    else $error("digit emitted after last digit");

  // Digits are only produced while the input side is busy.
  a_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> in_stall)
    else $error("emit while idle");
`endif

endmodule
